@@ rtl/core/lzss_window_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// lzss window decoder assertion macros
// Shared property macros for the concurrent checks in the decoder core.
// ----------------------------------------------------------------------------
`ifndef LZSS_WINDOW_DECODER_DEFINES_SVH
`define LZSS_WINDOW_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LZSSWD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LZSSWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lzsswd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzss window decoder package
// Shared constants and the command type passed from parser to copy engine.
// ----------------------------------------------------------------------------
package lzsswd_pkg;

    // window geometry
    localparam int WINDOW_SIZE = 4096;
    localparam int ADDR_W      = $clog2(WINDOW_SIZE);
    localparam int LOOKAHEAD   = 16;

    // write pointer start and end of the space-filled region
    localparam logic [ADDR_W-1:0] WP_RESET = ADDR_W'(WINDOW_SIZE - LOOKAHEAD);

    // fill bytes
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] FLAG_FILL  = 8'hff;

    // reference length field plus this gives the byte count
    localparam int LEN_ADD = 3;
    localparam int CNT_W   = 5;

    // command queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic
    {
        CMD_LITERAL,
        CMD_COPY
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t         kind;
        logic [7:0]        data;
        logic [ADDR_W-1:0] pos;
        logic [3:0]        len_field;
    } cmd_t;

endpackage

@@ rtl/core/lzss_window_decoder.sv @@
// ----------------------------------------------------------------------------
// lzss window decoder
// LZSS decompressor with a 4096-byte window, one compressed byte per request.
// ----------------------------------------------------------------------------
// After reset the block sweeps the window (spaces, then a zero tail) with
// s_axis_tready low. The parser then takes one byte per cycle while its
// two-entry command queue has room; flag bytes and low reference bytes
// produce no output. The copy engine emits a literal straight from the queue
// and a back reference byte by byte through the window RAM's single
// registered read port: each byte is read, then written back and presented.
// m_axis_tlast marks the final output byte of each token.
// ----------------------------------------------------------------------------
module lzss_window_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // run_last
);

    lzsswd_pkg::cmd_t push_cmd, head_cmd;
    logic             push, pop, empty, full, clear_done, accept;

    // input request handshake
    assign s_axis_tready = clear_done && !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // token parser
    lzsswd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (s_axis_tdata),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // command queue
    lzsswd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty),
        .full     (full)
    );

    // copy engine and window
    lzsswd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .empty      (empty),
        .pop        (pop),
        .clear_done (clear_done),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

@@ rtl/core/lzsswd_ram.sv @@
// ----------------------------------------------------------------------------
// lzsswd ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzsswd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/lzsswd_front.sv @@
// ----------------------------------------------------------------------------
// lzsswd front
// Parses flag bytes and tokens, pushes literal and copy commands.
// ----------------------------------------------------------------------------
module lzsswd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    output logic                push,
    output lzsswd_pkg::cmd_t    push_cmd
);

    typedef enum logic [1:0]
    {
        PH_FLAG,
        PH_TOKEN,
        PH_HIGH
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] flag_shift_reg, flag_shift_next;
    logic [7:0]  held_reg, held_next;

    // token decode
    always_comb
    begin
        phase_next          = phase_reg;
        flag_shift_next     = flag_shift_reg;
        held_next           = held_reg;
        push                = 1'b0;
        push_cmd.kind       = lzsswd_pkg::CMD_LITERAL;
        push_cmd.data       = in_byte;
        push_cmd.pos        = {in_byte[7:4], held_reg};
        push_cmd.len_field  = in_byte[3:0];
        if (accept)
        begin
            unique case (phase_reg)
                PH_TOKEN:
                begin
                    if (flag_shift_reg[0])
                    begin
                        push            = 1'b1;
                        flag_shift_next = {1'b0, flag_shift_reg[15:1]};
                        phase_next      = flag_shift_reg[9] ? PH_TOKEN : PH_FLAG;
                    end
                    else
                    begin
                        held_next  = in_byte;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    push            = 1'b1;
                    push_cmd.kind   = lzsswd_pkg::CMD_COPY;
                    flag_shift_next = {1'b0, flag_shift_reg[15:1]};
                    phase_next      = flag_shift_reg[9] ? PH_TOKEN : PH_FLAG;
                end
                default:
                begin
                    // flag byte, also the unused phase code
                    flag_shift_next = {lzsswd_pkg::FLAG_FILL, in_byte};
                    phase_next      = PH_TOKEN;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FLAG;
            flag_shift_reg <= 16'h0000;
            held_reg       <= 8'h00;
        end
        else
        begin
            phase_reg      <= phase_next;
            flag_shift_reg <= flag_shift_next;
            held_reg       <= held_next;
        end
    end

endmodule

@@ rtl/core/lzsswd_queue.sv @@
// ----------------------------------------------------------------------------
// lzsswd queue
// Short command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzsswd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lzsswd_pkg::cmd_t    push_cmd,
    input  logic                pop,
    output lzsswd_pkg::cmd_t    head_cmd,
    output logic                empty,
    output logic                full
);

    lzsswd_pkg::cmd_t                entry_reg [lzsswd_pkg::QUEUE_DEPTH];
    logic [lzsswd_pkg::QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [lzsswd_pkg::QPTR_W:0]     count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (lzsswd_pkg::QPTR_W+1)'(lzsswd_pkg::QUEUE_DEPTH));
    assign head_cmd = entry_reg[rptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/lzsswd_back.sv @@
// ----------------------------------------------------------------------------
// lzsswd back
// Clears the window, then carries out literal and copy commands.
// ----------------------------------------------------------------------------
`include "lzss_window_decoder_defines.svh"

module lzsswd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lzsswd_pkg::cmd_t    head_cmd,
    input  logic                empty,
    output logic                pop,
    output logic                clear_done,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

    state_t                              state_reg, state_next;
    logic [lzsswd_pkg::ADDR_W-1:0]       wp_reg, wp_next;
    logic [lzsswd_pkg::ADDR_W-1:0]       pos_reg, pos_next;
    logic [lzsswd_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic [7:0]                          out_byte_reg, out_byte_next;
    logic                                out_last_reg, out_last_next;

    logic                                ram_we, ram_re;
    logic [lzsswd_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [7:0]                          ram_wdata, ram_rdata;
    logic                                out_free;

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign clear_done = (state_reg != ST_CLEAR);
    assign ram_raddr  = pos_reg;

    // window memory
    lzsswd_ram #(
        .WIDTH (8),
        .DEPTH (lzsswd_pkg::WINDOW_SIZE)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // command sequencing
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = head_cmd.data;
        pop            = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // pos_reg doubles as the sweep address
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = (pos_reg < lzsswd_pkg::WP_RESET) ? lzsswd_pkg::SPACE_BYTE
                                                             : lzsswd_pkg::ZERO_BYTE;
                pos_next  = pos_reg + 1'b1;
                if (pos_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    if (head_cmd.kind == lzsswd_pkg::CMD_COPY)
                    begin
                        pop        = 1'b1;
                        pos_next   = head_cmd.pos;
                        cnt_next   = lzsswd_pkg::CNT_W'(head_cmd.len_field)
                                   + lzsswd_pkg::CNT_W'(lzsswd_pkg::LEN_ADD - 1);
                        state_next = ST_READ;
                    end
                    else if (out_free)
                    begin
                        // literal goes straight to window and output
                        pop            = 1'b1;
                        ram_we         = 1'b1;
                        wp_next        = wp_reg + 1'b1;
                        out_valid_next = 1'b1;
                        out_byte_next  = head_cmd.data;
                        out_last_next  = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = ram_rdata;
                    wp_next        = wp_reg + 1'b1;
                    pos_next       = pos_reg + 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_last_next  = (cnt_reg == '0);
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wp_reg        <= lzsswd_pkg::WP_RESET;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

    // checks
    `LZSSWD_ASSERT_NOW(a_no_out_in_clear, clk, rst_n, state_reg == ST_CLEAR, !out_valid_reg, "output valid during window clear")
    `LZSSWD_ASSERT_NOW(a_no_rw_overlap, clk, rst_n, ram_we, !ram_re, "window read and write in one cycle")
    `LZSSWD_ASSERT_NEXT(a_copy_continues, clk, rst_n, state_reg == ST_WRITE && out_free && cnt_reg != '0, state_reg == ST_READ && wp_reg == $past(wp_reg) + 1'b1, "copy did not advance to next byte")

endmodule

@@ bench/lzss_window_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzss window decoder testbench
// Feeds compressed byte streams (flag bytes, literals, back references) into
// the decoder and checks every decompressed byte and its tlast against a
// window model kept in a scoreboard. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module lzss_window_decoder_tb;

    // parser position within the compressed stream
    typedef enum logic [1:0]
    {
        EXPECT_FLAG,
        EXPECT_TOKEN,
        EXPECT_HIGH
    } stream_phase_t;

    // window model and queue of decoded bytes still to arrive
    class window_scoreboard;
        logic [7:0]                    win [lzsswd_pkg::WINDOW_SIZE];
        logic [lzsswd_pkg::ADDR_W-1:0] wr_ptr;
        logic [15:0]                   flag_bits;
        stream_phase_t                 phase;
        logic [7:0]                    low_byte;
        logic [8:0]                    decoded_q [$];   // {run_last, out_byte}
        int                            errors;

        function new();
            for (int i = 0; i < lzsswd_pkg::WINDOW_SIZE; i++)
                win[i] = (i < int'(lzsswd_pkg::WP_RESET)) ? lzsswd_pkg::SPACE_BYTE
                                                         : lzsswd_pkg::ZERO_BYTE;
            wr_ptr    = lzsswd_pkg::WP_RESET;
            flag_bits = '0;
            phase     = EXPECT_FLAG;
            low_byte  = '0;
            errors    = 0;
        endfunction

        // write one decoded byte to the window and queue it
        function void emit(logic [7:0] b, logic last);
            win[wr_ptr] = b;
            wr_ptr      = wr_ptr + 1'b1;
            decoded_q.push_back({last, b});
        endfunction

        function void next_token();
            flag_bits = flag_bits >> 1;
            phase     = flag_bits[8] ? EXPECT_TOKEN : EXPECT_FLAG;
        endfunction

        // one accepted compressed byte
        function void note_request(logic [7:0] b);
            logic [lzsswd_pkg::ADDR_W-1:0] src;
            int                            count;
            unique case (phase)
                EXPECT_TOKEN:
                begin
                    if (flag_bits[0])
                    begin
                        emit(b, 1'b1);
                        next_token();
                    end
                    else
                    begin
                        low_byte = b;
                        phase    = EXPECT_HIGH;
                    end
                end
                EXPECT_HIGH:
                begin
                    src   = {b[7:4], low_byte};
                    count = int'(b[3:0]) + lzsswd_pkg::LEN_ADD;
                    // byte by byte so a copy sees its own writes
                    for (int k = 0; k < count; k++)
                        emit(win[src + lzsswd_pkg::ADDR_W'(k)], k == count - 1);
                    next_token();
                end
                default:
                begin
                    flag_bits = {lzsswd_pkg::FLAG_FILL, b};
                    phase     = EXPECT_TOKEN;
                end
            endcase
        endfunction

        // one accepted output byte
        function void check_result(logic [7:0] data, logic last);
            logic [8:0] want;
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected output byte %02h last %0b", $time, data, last);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (data !== want[7:0])
            begin
                $display("%0t: out_byte mismatch, expected %02h got %02h",
                         $time, want[7:0], data);
                errors++;
            end
            if (last !== want[8])
            begin
                $display("%0t: run_last mismatch, expected %0b got %0b",
                         $time, want[8], last);
                errors++;
            end
        endfunction

        function int outstanding();
            return decoded_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] out_byte
    logic       m_axis_tlast;    // run_last

    window_scoreboard sb;
    int               sent_count;
    int               stall_left;
    bit               calm_phase;

    lzss_window_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one compressed byte through the input handshake
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(b);
        sent_count++;
        calm_phase = ((sent_count / 40) % 4) == 3;
    endtask

    task automatic send_reference(input logic [lzsswd_pkg::ADDR_W-1:0] src,
                                  input logic [3:0] len_field);
        send_byte(src[7:0]);
        send_byte({src[11:8], len_field});
    endtask

    // random flag group: literals and references, mostly near the write pointer
    task automatic send_random_group();
        logic [7:0]                    flag;
        logic [lzsswd_pkg::ADDR_W-1:0] src;
        logic [3:0]                    len_field;
        int                            r;
        r    = $urandom_range(0, 9);
        flag = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom);
        send_byte(flag);
        for (int i = 0; i < 8; i++)
        begin
            if (flag[i])
                send_byte(8'($urandom));
            else
            begin
                r = $urandom_range(0, 3);
                if (r < 2)
                    src = sb.wr_ptr - lzsswd_pkg::ADDR_W'($urandom_range(1, 40));
                else if (r == 2)
                    src = lzsswd_pkg::ADDR_W'($urandom);
                else
                    src = sb.wr_ptr - lzsswd_pkg::ADDR_W'($urandom_range(0, 3));
                len_field = ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                        : 4'($urandom_range(0, 5));
                send_reference(src, len_field);
            end
        end
    endtask

    // output side: random stalls, check every accepted byte
    initial
    begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap();
            m_axis_tready <= (stall_left == 0);
        end
    end

    // stimulus and end of run
    initial
    begin
        sb            = new();
        sent_count    = 0;
        calm_phase    = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lit, lit, ref, ref, lit, ref, ref, ref
        send_byte(8'h13);
        send_byte(8'h00);
        send_byte(8'hff);
        // spaces from the bottom of the window, shortest copy
        send_reference(12'h000, 4'h0);
        // from the first written byte, longest copy: overlaps itself and wraps
        send_reference(lzsswd_pkg::WP_RESET, 4'hf);
        send_byte(8'h5a);
        // run of the byte just written
        send_reference(sb.wr_ptr - 1'b1, 4'hf);
        // top window entry
        send_reference(12'hfff, 4'h0);
        // entry about to be overwritten
        send_reference(sb.wr_ptr, 4'h7);
        // eight literals in one group
        send_byte(8'hff);
        for (int i = 0; i < 8; i++)
            send_byte(8'($urandom));

        while (sent_count < 270)
            send_random_group();
        // leave a reference half sent: it must stay pending
        send_byte(8'h00);
        send_byte(8'($urandom));

        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("lzss_window_decoder_tb: done, clean");
        else
            $display("lzss_window_decoder_tb: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("lzss_window_decoder_tb: done, errors");
        $finish;
    end

endmodule

@@ lzss_window_decoder.f @@
+incdir+rtl/core
rtl/core/lzsswd_pkg.sv
rtl/core/lzsswd_ram.sv
rtl/core/lzsswd_front.sv
rtl/core/lzsswd_queue.sv
rtl/core/lzsswd_back.sv
rtl/core/lzss_window_decoder.sv
bench/lzss_window_decoder_tb.sv
